// File: rtl/mtb_pkg.sv
// Shared types and constants for the timer bank: commands, modes,
// scan states and the structs passed between the top level and the cells.
// No dependencies.
package mtb_pkg;

    localparam int MTB_NUM_SLOTS  = 8;
    localparam int MTB_COUNT_BITS = 32;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_SETUP     = 3'd1,
        CMD_START     = 3'd2,
        CMD_STOP      = 3'd3,
        CMD_SET_PER   = 3'd4,
        CMD_SET_BOTH  = 3'd5,
        CMD_QUERY     = 3'd6,
        CMD_NOP       = 3'd7
    } cmd_t;

    localparam logic [1:0] MODE_SINGLE    = 2'd0;
    localparam logic [1:0] MODE_PERIODIC  = 2'd1;
    localparam logic [1:0] MODE_TWO_PHASE = 2'd2;

    localparam logic KIND_EXPIRY = 1'b0;
    localparam logic KIND_REPLY  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } scan_state_t;

    typedef struct packed {
        logic        apply;
        cmd_t        cmd;
        logic [2:0]  index;
        logic [1:0]  mode;
        logic [31:0] period_a;
        logic [31:0] period_b;
    } cell_cmd_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] slot;
        logic       phase;
        logic       running;
    } cell_evt_t;

    typedef struct packed {
        logic        phase;
        logic        running;
        logic [31:0] ticks;
    } cell_stat_t;

endpackage

// File: rtl/mtb_if.sv
// Valid/ready channel interfaces for the timer bank command and result streams.
// No dependencies.
interface mtb_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [2:0]  timer_index;
    logic [1:0]  timer_mode;
    logic [31:0] period_a;
    logic [31:0] period_b;

    modport source (output valid, cmd, timer_index, timer_mode, period_a, period_b,
                    input ready);
    modport sink   (input valid, cmd, timer_index, timer_mode, period_a, period_b,
                    output ready);
endinterface

interface mtb_rsp_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [2:0]  slot;
    logic        phase;
    logic        running;
    logic [31:0] ticks_left;
    logic        last;

    modport source (output valid, kind, slot, phase, running, ticks_left, last,
                    input ready);
    modport sink   (input valid, kind, slot, phase, running, ticks_left, last,
                    output ready);
endinterface

// File: rtl/mtb_cell.sv
// One timer slot: mode, periods, run flag, phase and countdown, plus the
// scan token stage handed to the next cell. Depends on mtb_pkg.
module mtb_cell #(
    parameter int COUNT_BITS = 32,
    parameter int CELL_ID    = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mtb_pkg::cell_cmd_t ccmd,
    input  logic               shift,
    input  logic               token_in,
    output logic               token_out,
    output mtb_pkg::cell_evt_t evt,
    output mtb_pkg::cell_stat_t stat
);
    import mtb_pkg::*;

    localparam logic [31:0] CELL_KEY = 32'(CELL_ID);

    logic                  token_reg, token_next;
    logic                  in_use_reg, in_use_next;
    logic                  run_reg, run_next;
    logic                  phase_reg, phase_next;
    logic [1:0]            mode_reg, mode_next;
    logic [COUNT_BITS-1:0] first_reg, first_next;
    logic [COUNT_BITS-1:0] second_reg, second_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic                  match;
    logic [COUNT_BITS-1:0] pa, pb, dec;
    logic                  expire, exp_phase, exp_run;

    assign match = ({29'd0, ccmd.index} == CELL_KEY);
    assign pa    = COUNT_BITS'(ccmd.period_a);
    assign pb    = COUNT_BITS'(ccmd.period_b);
    assign dec   = (count_reg == '0) ? '0 : count_reg - 1'b1;

    assign expire    = in_use_reg && run_reg && (dec == '0);
    assign exp_run   = (mode_reg == MODE_SINGLE) ? 1'b0 : run_reg;
    assign exp_phase = (mode_reg == MODE_TWO_PHASE) ? ~phase_reg : phase_reg;

    assign token_next = shift ? token_in : token_reg;
    assign token_out  = token_reg;

    assign evt.hit     = token_reg && expire;
    assign evt.slot    = 3'(CELL_ID);
    assign evt.phase   = exp_phase;
    assign evt.running = exp_run;

    assign stat.phase   = match && phase_reg;
    assign stat.running = match && run_reg;
    assign stat.ticks   = match ? 32'(count_reg) : 32'd0;

    always_comb
    begin
        in_use_next = in_use_reg;
        run_next    = run_reg;
        phase_next  = phase_reg;
        mode_next   = mode_reg;
        first_next  = first_reg;
        second_next = second_reg;
        count_next  = count_reg;
        if (token_reg && shift && in_use_reg && run_reg)
        begin
            if (expire)
            begin
                run_next   = exp_run;
                phase_next = exp_phase;
                count_next = exp_phase ? second_reg : first_reg;
            end
            else
            begin
                count_next = dec;
            end
        end
        else if (ccmd.apply && match)
        begin
            unique case (ccmd.cmd)
                CMD_SETUP:
                begin
                    in_use_next = 1'b1;
                    run_next    = 1'b0;
                    phase_next  = 1'b0;
                    mode_next   = ccmd.mode;
                    first_next  = pa;
                    second_next = (ccmd.mode == MODE_TWO_PHASE) ? pb : '0;
                    count_next  = pa;
                end
                CMD_START:
                begin
                    if (in_use_reg)
                    begin
                        run_next   = 1'b1;
                        phase_next = 1'b0;
                        count_next = first_reg;
                    end
                end
                CMD_STOP:
                begin
                    if (in_use_reg)
                    begin
                        run_next = 1'b0;
                    end
                end
                CMD_SET_PER:
                begin
                    if (in_use_reg)
                    begin
                        first_next = pa;
                        count_next = phase_reg ? second_reg : pa;
                    end
                end
                CMD_SET_BOTH:
                begin
                    if (in_use_reg)
                    begin
                        phase_next  = 1'b0;
                        first_next  = pa;
                        second_next = pb;
                        count_next  = pa;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg  <= 1'b0;
            in_use_reg <= 1'b0;
            run_reg    <= 1'b0;
            phase_reg  <= 1'b0;
            mode_reg   <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            token_reg  <= token_next;
            in_use_reg <= in_use_next;
            run_reg    <= run_next;
            phase_reg  <= phase_next;
            mode_reg   <= mode_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/multi_timer_bank_core.sv
// Top level of the timer bank: a chain of slot cells, the tick scan control
// and the result register. Depends on mtb_pkg, mtb_if and mtb_cell.
//
//   channel  role     transfer carries
//   req      sink     cmd, timer_index, timer_mode, period_a, period_b
//   rsp      source   kind, slot, phase, running, ticks_left, last
//
// Setup, start, stop, retime and query act when the request is accepted.
// A tick passes a token down the cell chain, one slot per cycle while no
// expiry event waits on a stalled rsp, and runs through transfer, scan and
// flush steps.
// Each expiry event is held in hold_reg until the next one comes, so the final one can carry last.
// req.ready is high only while no tick is in progress and the result register
// can load. Reset clears all slots, the token and the result valid flag.
module multi_timer_bank_core #(
    parameter int NUM_SLOTS  = mtb_pkg::MTB_NUM_SLOTS,
    parameter int COUNT_BITS = mtb_pkg::MTB_COUNT_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    mtb_req_if.sink   req,
    mtb_rsp_if.source rsp
);
    import mtb_pkg::*;

    scan_state_t state_reg, state_next;
    cell_evt_t   hold_reg, hold_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [2:0]  out_slot_reg, out_slot_next;
    logic        out_phase_reg, out_phase_next;
    logic        out_run_reg, out_run_next;
    logic [31:0] out_ticks_reg, out_ticks_next;
    logic        out_last_reg, out_last_next;

    cell_cmd_t              ccmd;
    logic                   out_free, accept, shift, tick_start;
    logic [NUM_SLOTS-1:0]   tok;
    cell_evt_t              evt [NUM_SLOTS];
    cell_stat_t             stat [NUM_SLOTS];
    cell_evt_t              ev_any;
    cell_stat_t             stat_any;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign ccmd.apply    = accept;
    assign ccmd.cmd      = cmd_t'(req.cmd);
    assign ccmd.index    = req.timer_index;
    assign ccmd.mode     = req.timer_mode;
    assign ccmd.period_a = req.period_a;
    assign ccmd.period_b = req.period_b;

    assign tick_start = accept && (cmd_t'(req.cmd) == CMD_TICK);

    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOTS; gi++)
        begin : g_cell
            logic tin;
            if (gi == 0)
            begin : g_head
                assign tin = tick_start;
            end
            else
            begin : g_link
                assign tin = tok[gi-1];
            end
            mtb_cell #(
                .COUNT_BITS (COUNT_BITS),
                .CELL_ID    (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ccmd      (ccmd),
                .shift     (shift),
                .token_in  (tin),
                .token_out (tok[gi]),
                .evt       (evt[gi]),
                .stat      (stat[gi])
            );
        end
    endgenerate

    always_comb
    begin
        ev_any   = '0;
        stat_any = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (evt[i].hit)
            begin
                ev_any = ev_any | evt[i];
            end
            stat_any = stat_any | stat[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        hold_next      = hold_reg;
        shift          = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_kind_next  = out_kind_reg;
        out_slot_next  = out_slot_reg;
        out_phase_next = out_phase_reg;
        out_run_next   = out_run_reg;
        out_ticks_next = out_ticks_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_start)
                begin
                    shift      = 1'b1;
                    hold_next  = '0;
                    state_next = ST_SCAN;
                end
                else if (accept && (cmd_t'(req.cmd) == CMD_QUERY))
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_REPLY;
                    out_slot_next  = req.timer_index;
                    out_phase_next = stat_any.phase;
                    out_run_next   = stat_any.running;
                    out_ticks_next = stat_any.ticks;
                    out_last_next  = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (!(ev_any.hit && hold_reg.hit && !out_free))
                begin
                    shift = 1'b1;
                    if (ev_any.hit)
                    begin
                        if (hold_reg.hit)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_EXPIRY;
                            out_slot_next  = hold_reg.slot;
                            out_phase_next = hold_reg.phase;
                            out_run_next   = hold_reg.running;
                            out_ticks_next = 32'd0;
                            out_last_next  = 1'b0;
                        end
                        hold_next = ev_any;
                    end
                    if (tok[NUM_SLOTS-1])
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!hold_reg.hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_EXPIRY;
                    out_slot_next  = hold_reg.slot;
                    out_phase_next = hold_reg.phase;
                    out_run_next   = hold_reg.running;
                    out_ticks_next = 32'd0;
                    out_last_next  = 1'b1;
                    hold_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_phase_reg <= out_phase_next;
        out_run_reg   <= out_run_next;
        out_ticks_reg <= out_ticks_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.kind       = out_kind_reg;
    assign rsp.slot       = out_slot_reg;
    assign rsp.phase      = out_phase_reg;
    assign rsp.running    = out_run_reg;
    assign rsp.ticks_left = out_ticks_reg;
    assign rsp.last       = out_last_reg;

endmodule
